// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the text console engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define TCCE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define TCCE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/tcce_pkg.sv -----
// Shared types and constants for the text console character engine.
package tcce_pkg;

   localparam int unsigned CMD_W      = 2;
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned IDX_W      = 11;
   localparam int unsigned COL_OUT_W  = 7;
   localparam int unsigned ROW_OUT_W  = 5;
   localparam int unsigned POS_OUT_W  = 11;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

   localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h0F;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic put;
      logic home;
      logic read_issue;
      logic copy_step;
      logic zero_step;
      logic load_all;
      logic load_copy;
      logic load_bottom;
      logic row_dec;
      logic shown_update;
      logic rsp_load;
   } tcce_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             need_scroll;
      logic             last_copy;
      logic             last_zero;
      logic             rsp_free;
   } tcce_stat_type;

endpackage

// ----- hdl/tcce_ctrl.sv -----
// Sequencer for put, clear, read, scroll and the power-up clearing sweep.
module tcce_ctrl
   import tcce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  tcce_stat_type stat,
   output tcce_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_COPY,
      ST_DRAIN,
      ST_ZERO,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.zero_step = 1'b1;
            if (stat.last_zero) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.cmd)
               CMD_PUT: begin
                  cmd.put  = 1'b1;
                  state_in = ST_CHECK;
               end
               CMD_CLEAR: begin
                  cmd.home     = 1'b1;
                  cmd.load_all = 1'b1;
                  state_in     = ST_ZERO;
               end
               CMD_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in       = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_CHECK: begin
            if (stat.need_scroll) begin
               cmd.row_dec   = 1'b1;
               cmd.load_copy = 1'b1;
               state_in      = ST_COPY;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (stat.last_copy) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // last copied cell is written here; the row address has settled
            cmd.load_bottom  = 1'b1;
            cmd.shown_update = 1'b1;
            state_in         = ST_ZERO;
         end
         ST_ZERO: begin
            cmd.zero_step = 1'b1;
            if (stat.last_zero) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule

// ----- hdl/tcce_datapath.sv -----
// Cell store, cursor registers, sweep counter and result register.
module tcce_datapath
   import tcce_pkg::*;
#(
   parameter int unsigned COLS     = 80,
   parameter int unsigned ROWS     = 25,
   parameter int unsigned TAB_STEP = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   input  logic [CHAR_W-1:0]     csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  tcce_cmd_type          cmd,
   output tcce_stat_type         stat
);

   localparam int unsigned CELLS  = COLS * ROWS;
   localparam int unsigned ADDR_W = $clog2(CELLS);
   localparam int unsigned COL_W  = $clog2(COLS);
   localparam int unsigned NCOL_W = $clog2(COLS + TAB_STEP);
   localparam int unsigned ROW_W  = $clog2(ROWS);
   localparam int unsigned PH_W   = $clog2(TAB_STEP);
   localparam int unsigned COPY_END   = (ROWS - 1) * COLS - 1;
   localparam int unsigned BOTTOM_ROW = (ROWS - 2) * COLS;

   logic [CHAR_W-1:0] char_mem [CELLS];
   logic [CHAR_W-1:0] attr_mem [CELLS];

   logic [CMD_W-1:0]  cmd_ff;
   logic [CHAR_W-1:0] code_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CHAR_W-1:0] attr_ff;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PH_W-1:0]   ph_ff, ph_in;       // col mod TAB_STEP
   logic [ADDR_W-1:0] here_ff, here_in;   // row*COLS+col
   logic [ADDR_W-1:0] shown_ff;

   logic [ADDR_W-1:0] sweep_ff;
   logic              copy_pend_ff;
   logic [ADDR_W-1:0] copy_dst_ff;

   logic [CHAR_W-1:0] rd_char_ff, rd_attr_ff;
   logic              in_range_ff;

   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_attr_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic [POS_OUT_W-1:0] rsp_pos_ff;

   logic [NCOL_W-1:0] ncol;
   logic              row_inc;
   logic              put_we_char, put_we_attr;
   logic [ADDR_W-1:0] put_addr;
   logic [CHAR_W-1:0] put_char;

   logic              we_char, we_attr;
   logic [ADDR_W-1:0] wr_addr;
   logic [CHAR_W-1:0] wr_char, wr_attr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              idx_ok;

   // cursor update for a put, a clear (home) and a scroll (row_dec)
   always_comb begin
      ncol        = NCOL_W'(col_ff);
      ph_in       = ph_ff;
      row_inc     = 1'b0;
      put_we_char = 1'b0;
      put_we_attr = 1'b0;
      put_addr    = here_ff;
      put_char    = code_ff;
      case (code_ff)
         CH_BS: begin
            if (col_ff != '0) begin
               ncol        = NCOL_W'(col_ff) - NCOL_W'(1);
               ph_in       = (ph_ff == '0) ? PH_W'(TAB_STEP - 1) : ph_ff - PH_W'(1);
               put_addr    = here_ff - ADDR_W'(1);
               put_char    = '0;
               put_we_char = 1'b1;
            end
         end
         CH_TAB: begin
            ncol  = NCOL_W'(col_ff) + NCOL_W'(TAB_STEP) - NCOL_W'(ph_ff);
            ph_in = '0;
         end
         CH_CR: begin
            ncol  = '0;
            ph_in = '0;
         end
         CH_LF: begin
            ncol    = '0;
            ph_in   = '0;
            row_inc = 1'b1;
         end
         default: begin
            ncol        = NCOL_W'(col_ff) + NCOL_W'(1);
            ph_in       = (ph_ff == PH_W'(TAB_STEP - 1)) ? '0 : ph_ff + PH_W'(1);
            put_we_char = 1'b1;
            put_we_attr = 1'b1;
         end
      endcase
      if (ncol >= NCOL_W'(COLS)) begin
         ncol    = '0;
         ph_in   = '0;
         row_inc = 1'b1;
      end

      col_in = col_ff;
      row_in = row_ff;
      if (cmd.put) begin
         col_in = COL_W'(ncol);
         row_in = row_ff + ROW_W'(row_inc);
      end else begin
         ph_in = ph_ff;
      end
      if (cmd.home) begin
         col_in = '0;
         row_in = '0;
         ph_in  = '0;
      end
      if (cmd.row_dec) row_in = row_ff - ROW_W'(1);
   end

   assign here_in = ADDR_W'(32'(row_ff) * 32'(COLS) + 32'(col_ff));
   assign idx_ok  = 32'(idx_ff) < 32'(CELLS);

   // one write port: pending copy, then sweep zeroing, then put
   always_comb begin
      we_char = 1'b0;
      we_attr = 1'b0;
      wr_addr = put_addr;
      wr_char = put_char;
      wr_attr = attr_ff;
      if (copy_pend_ff) begin
         we_char = 1'b1;
         we_attr = 1'b1;
         wr_addr = copy_dst_ff;
         wr_char = rd_char_ff;
         wr_attr = rd_attr_ff;
      end else if (cmd.zero_step) begin
         we_char = 1'b1;
         we_attr = 1'b1;
         wr_addr = sweep_ff;
         wr_char = '0;
         wr_attr = '0;
      end else if (cmd.put) begin
         we_char = put_we_char;
         we_attr = put_we_attr;
      end
   end

   assign rd_en   = cmd.read_issue | cmd.copy_step;
   assign rd_addr = cmd.read_issue ? ADDR_W'(idx_ff) : sweep_ff;

   always_ff @(posedge clock) begin
      if (we_char) char_mem[wr_addr] <= wr_char;
      if (we_attr) attr_mem[wr_addr] <= wr_attr;
      if (rd_en) begin
         rd_char_ff <= char_mem[rd_addr];
         rd_attr_ff <= attr_mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      here_ff <= here_in;
      if (cmd.capture) begin
         cmd_ff  <= req_tuser;
         code_ff <= req_tdata[CHAR_W-1:0];
         idx_ff  <= req_tdata[CHAR_W +: IDX_W];
      end
      if (cmd.read_issue) in_range_ff <= idx_ok;
      if (cmd.copy_step) copy_dst_ff <= sweep_ff - ADDR_W'(COLS);
      if (cmd.rsp_load) begin
         rsp_char_ff <= (cmd_ff == CMD_READ && in_range_ff) ? rd_char_ff : '0;
         rsp_attr_ff <= (cmd_ff == CMD_READ && in_range_ff) ? rd_attr_ff : '0;
         rsp_col_ff  <= COL_OUT_W'(col_ff);
         rsp_row_ff  <= ROW_OUT_W'(row_ff);
         rsp_pos_ff  <= POS_OUT_W'(shown_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         ph_ff        <= '0;
         shown_ff     <= '0;
         attr_ff      <= ATTR_RESET;
         sweep_ff     <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         ph_ff  <= ph_in;
         if (cmd.home) shown_ff <= '0;
         else if (cmd.shown_update) shown_ff <= here_ff;
         if (csr_valid) attr_ff <= csr_data;
         if (cmd.load_all) sweep_ff <= '0;
         else if (cmd.load_copy) sweep_ff <= ADDR_W'(COLS);
         else if (cmd.load_bottom) sweep_ff <= ADDR_W'(BOTTOM_ROW);
         else if (cmd.copy_step || cmd.zero_step) sweep_ff <= sweep_ff + ADDR_W'(1);
         copy_pend_ff <= cmd.copy_step;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.cmd         = cmd_ff;
   assign stat.need_scroll = 32'(row_ff) >= 32'(ROWS - 1);
   assign stat.last_copy   = sweep_ff == ADDR_W'(COPY_END);
   assign stat.last_zero   = sweep_ff == ADDR_W'(CELLS - 1);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_pos_ff, rsp_row_ff, rsp_col_ff, rsp_attr_ff, rsp_char_ff};

endmodule

// ----- hdl/text_console_char_engine.sv -----
// Top level of the text console character engine.
//
//   channel  dir  handshake              contents
//   req      in   req_tvalid/tready      tuser cmd, tdata char_code, cell_index
//   rsp      out  rsp_tvalid/tready      tdata char, attr, col, row, shown pos
//   csr      in   csr_valid/ready        char_attribute byte
//
// Read and undefined commands pass EXEC and DONE, a put without scroll EXEC, CHECK, DONE.
// A put that scrolls walks the cell store one cell per cycle through the single
// write port, then zeroes the bottom two rows; a clear zeroes every cell.
// After reset the store is swept clear with req_tready low.
// A finished word waits in the result register; req_tready returns while it waits.
module text_console_char_engine
   import tcce_pkg::*;
#(
   parameter int unsigned COLS     = 80,
   parameter int unsigned ROWS     = 25,
   parameter int unsigned TAB_STEP = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CMD_W-1:0]      req_tuser,  // cmd
   input  logic [REQ_DATA_W-1:0] req_tdata,  // char_code, cell_index, pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // read_char, read_attr, cursor_col, cursor_row, shown_cursor_pos, pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CHAR_W-1:0]     csr_data
);

   tcce_cmd_type  cmd;
   tcce_stat_type stat;

   assign csr_ready = 1'b1;

   tcce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcce_datapath #(
      .COLS     (COLS),
      .ROWS     (ROWS),
      .TAB_STEP (TAB_STEP)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ----- hdl/tcce_checker.sv -----
// Port-level checks for the text console character engine, bound to the top.
`include "assert_macros.svh"

module tcce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   `TCCE_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled rsp word changed")
   `TCCE_ASSERT(a_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready, "req taken while busy")
   `TCCE_ASSERT_ALWAYS(a_init_sweep, clock, reset |=> !req_tready, "req ready during clearing sweep")

endmodule

bind text_console_char_engine tcce_checker u_tcce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- dv/tb.sv -----
// Self-checking testbench for the text console character engine.
`timescale 1ns / 1ps

module tb
   import tcce_pkg::*;
();

   localparam int SCREEN_COLS  = 80;
   localparam int SCREEN_ROWS  = 25;
   localparam int TAB_WIDTH    = 8;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
   localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;
   localparam int PHASE_WORDS  = 92;
   localparam int MAX_CYCLES   = 8_000_000;
   localparam int TAIL_CYCLES  = 2100;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] code;
      logic [IDX_W-1:0]  index;
   } console_req_type;

   typedef struct {
      logic [CHAR_W-1:0]    read_char;
      logic [CHAR_W-1:0]    read_attr;
      logic [COL_OUT_W-1:0] col;
      logic [ROW_OUT_W-1:0] row;
      logic [POS_OUT_W-1:0] shown;
   } console_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CMD_W-1:0]      req_tuser = '0;       // cmd
   logic [REQ_DATA_W-1:0] req_tdata = '0;       // char_code, cell_index, pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // read_char, read_attr, cursor_col, cursor_row, shown_cursor_pos, pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CHAR_W-1:0]     csr_data = '0;

   text_console_char_engine #(
      .COLS     (SCREEN_COLS),
      .ROWS     (SCREEN_ROWS),
      .TAB_STEP (TAB_WIDTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // shadow of the console state
   logic [CHAR_W-1:0] cell_char [SCREEN_CELLS];
   logic [CHAR_W-1:0] cell_attr [SCREEN_CELLS];
   int                cur_col, cur_row, shown_pos;
   logic [CHAR_W-1:0] cur_attr;

   console_req_type pending_words [$];
   console_rsp_type expected_rsp [$];
   int              errors = 0;
   int              words_seen = 0;
   int              cycles = 0;

   function automatic void clear_screen();
      for (int i = 0; i < SCREEN_CELLS; i++) begin
         cell_char[i] = '0;
         cell_attr[i] = '0;
      end
      cur_col   = 0;
      cur_row   = 0;
      shown_pos = 0;
   endfunction

   function automatic console_rsp_type console_step(input logic [CMD_W-1:0] op,
                                                    input logic [CHAR_W-1:0] code,
                                                    input logic [IDX_W-1:0] idx);
      console_rsp_type r;
      int here;
      r.read_char = '0;
      r.read_attr = '0;
      case (op)
         CMD_PUT: begin
            here = cur_row * SCREEN_COLS + cur_col;
            case (code)
               CH_BS: begin
                  if (cur_col > 0) begin
                     cur_col--;
                     cell_char[cur_row * SCREEN_COLS + cur_col] = '0;
                  end
               end
               CH_TAB: begin
                  cur_col = cur_col + TAB_WIDTH - ((cur_col + TAB_WIDTH) % TAB_WIDTH);
               end
               CH_CR: begin
                  cur_col = 0;
               end
               CH_LF: begin
                  cur_col = 0;
                  cur_row++;
               end
               default: begin
                  cell_char[here] = code;
                  cell_attr[here] = cur_attr;
                  cur_col++;
               end
            endcase
            if (cur_col >= SCREEN_COLS) begin
               cur_col = 0;
               cur_row++;
            end
            // scroll up one row, bottom two rows blank
            if (cur_row >= SCREEN_ROWS - 1) begin
               for (int i = 0; i < SCREEN_COLS * (SCREEN_ROWS - 1); i++) begin
                  cell_char[i] = cell_char[i + SCREEN_COLS];
                  cell_attr[i] = cell_attr[i + SCREEN_COLS];
               end
               for (int i = SCREEN_COLS * (SCREEN_ROWS - 2); i < SCREEN_CELLS; i++) begin
                  cell_char[i] = '0;
                  cell_attr[i] = '0;
               end
               cur_row--;
               shown_pos = cur_row * SCREEN_COLS + cur_col;
            end
         end
         CMD_CLEAR: begin
            clear_screen();
         end
         CMD_READ: begin
            if (idx < SCREEN_CELLS) begin
               r.read_char = cell_char[idx];
               r.read_attr = cell_attr[idx];
            end
         end
         default: begin
         end
      endcase
      r.col   = cur_col[COL_OUT_W-1:0];
      r.row   = cur_row[ROW_OUT_W-1:0];
      r.shown = shown_pos[POS_OUT_W-1:0];
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      errors++;
      if (errors <= 40)
         $display("ERROR word %0d: %s got %0d want %0d", words_seen, what, got, want);
   endtask

   // sender: bursts of random length, random gaps between them
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      console_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0 || pending_words.size() == 0) begin
            req_tvalid <= 1'b0;
            if (gap_left > 0)
               gap_left--;
         end else begin
            nxt = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.cmd;
            req_tdata  <= {5'd0, nxt.index, nxt.code};
            if (burst_left > 0)
               burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
      end
   end

   // receiver: stall pattern picked at random from four modes, plus two long hold-offs
   int hold_left = 0;
   int hold_mark = -1;
   int stall_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left == 0 && (words_seen == 100 || words_seen == 450)
             && hold_mark != words_seen) begin
            hold_left = 400;
            hold_mark = words_seen;
         end
         if (cycles % 256 == 0)
            stall_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 9) < 7);
               2: rsp_tready <= cycles[2];
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // monitor: check results first, then predict the word taken this edge
   always @(posedge clock) begin
      console_rsp_type want;
      if (reset) begin
         clear_screen();
         cur_attr = ATTR_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen <= words_seen + 1;
            if (expected_rsp.size() == 0) begin
               flag_mismatch("word with nothing pending, tdata", int'(rsp_tdata[31:0]), 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tdata[7:0] !== want.read_char)
                  flag_mismatch("read_char", int'(rsp_tdata[7:0]), int'(want.read_char));
               if (rsp_tdata[15:8] !== want.read_attr)
                  flag_mismatch("read_attr", int'(rsp_tdata[15:8]), int'(want.read_attr));
               if (rsp_tdata[22:16] !== want.col)
                  flag_mismatch("cursor_col", int'(rsp_tdata[22:16]), int'(want.col));
               if (rsp_tdata[27:23] !== want.row)
                  flag_mismatch("cursor_row", int'(rsp_tdata[27:23]), int'(want.row));
               if (rsp_tdata[38:28] !== want.shown)
                  flag_mismatch("shown_cursor_pos", int'(rsp_tdata[38:28]),
                                int'(want.shown));
            end
         end
         if (req_tvalid && req_tready)
            expected_rsp.push_back(console_step(req_tuser, req_tdata[7:0],
                                                req_tdata[18:8]));
         if (csr_valid && csr_ready)
            cur_attr = csr_data;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= MAX_CYCLES) begin
         $display("text_console_char_engine: mismatch");
         $finish;
      end
   end

   task automatic queue_word(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] code,
                             input logic [IDX_W-1:0] idx);
      console_req_type it;
      it.cmd   = op;
      it.code  = code;
      it.index = idx;
      pending_words.push_back(it);
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_attr(input logic [CHAR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // profile 0: running text, 1: line heavy (lots of scrolling), 2: read heavy
   function automatic console_req_type random_word(input int profile);
      console_req_type it;
      int roll, rd_pct, lf_pct, lo_row;
      it.cmd   = CMD_PUT;
      it.code  = CHAR_W'($urandom_range(0, 255));
      it.index = IDX_W'($urandom_range(0, 2047));
      rd_pct   = (profile == 2) ? 40 : 15;
      lf_pct   = (profile == 1) ? 30 : 5;
      roll     = $urandom_range(0, 99);
      if (roll < 1) begin
         it.cmd = CMD_CLEAR;
      end else if (roll < 4) begin
         it.cmd = CMD_UNDEF;
      end else if (roll < 4 + rd_pct) begin
         it.cmd = CMD_READ;
         roll   = $urandom_range(0, 9);
         if (roll < 5) begin
            // rows near the cursor, where text was just written
            lo_row   = (cur_row > 3) ? cur_row - 3 : 0;
            it.index = IDX_W'($urandom_range(lo_row, cur_row + 1) * SCREEN_COLS
                              + $urandom_range(0, SCREEN_COLS - 1));
         end else if (roll == 5) begin
            it.index = IDX_W'($urandom_range(SCREEN_CELLS, 2047));
         end
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < lf_pct)
            it.code = CH_LF;
         else if (roll < lf_pct + 4)
            it.code = CH_BS;
         else if (roll < lf_pct + 7)
            it.code = CH_TAB;
         else if (roll < lf_pct + 9)
            it.code = CH_CR;
      end
      return it;
   endfunction

   initial begin
      logic [CHAR_W-1:0] attr_plan [8];
      attr_plan = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h01, 8'h7F, 8'h00};
      attr_plan[2] = CHAR_W'($urandom_range(0, 255));
      attr_plan[4] = CHAR_W'($urandom_range(0, 255));
      attr_plan[7] = CHAR_W'($urandom_range(0, 255));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset attribute still in force
      queue_word(CMD_READ, 8'h00, 11'd0);
      queue_word(CMD_PUT, 8'h00, 11'd0);
      queue_word(CMD_PUT, 8'hFF, 11'h7FF);
      queue_word(CMD_PUT, CH_BS, 11'd0);
      queue_word(CMD_READ, 8'h00, 11'd1);       // char gone, attribute kept
      queue_word(CMD_PUT, CH_TAB, 11'd0);
      queue_word(CMD_PUT, CH_TAB, 11'd0);
      queue_word(CMD_PUT, CH_CR, 11'd0);
      queue_word(CMD_PUT, CH_BS, 11'd0);       // backspace at column 0
      queue_word(CMD_PUT, CH_LF, 11'd0);
      queue_word(CMD_READ, 8'hFF, 11'd0);
      queue_word(CMD_READ, 8'h00, 11'd1999);
      queue_word(CMD_READ, 8'h00, 11'd2000);    // past the last cell
      queue_word(CMD_READ, 8'h00, 11'h7FF);
      queue_word(CMD_UNDEF, 8'hFF, 11'h7FF);
      queue_word(CMD_PUT, 8'h41, 11'd0);
      queue_word(CMD_READ, 8'h00, 11'd80);
      queue_word(CMD_CLEAR, 8'hFF, 11'h7FF);
      queue_word(CMD_READ, 8'h00, 11'd0);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         write_attr(attr_plan[p]);
         @(negedge clock);
         for (int n = 0; n < PHASE_WORDS; n++)
            pending_words.push_back(random_word(p % 3));
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("text_console_char_engine: match");
      else
         $display("text_console_char_engine: mismatch");
      $finish;
   end

endmodule
